### hdl/sgc_pkg.sv
// ----------------------------------------------------------------------------
// sgc_pkg: shared types and constants of the semigroup node expander
// Request and result layouts, cell bus, index widths and small helpers.
// ----------------------------------------------------------------------------
package sgc_pkg;

	localparam int MAX_FROB = 63;
	localparam int F_W      = 6;
	localparam int MEMB_W   = 64;
	localparam int IDX_SPAN = 128;
	localparam int IDX_W    = 7;
	localparam int M_W      = 7;
	localparam int CNT_W    = 6;
	localparam int BYTE_W   = 8;

	// last shift amount of the sums pass: ceil(127 / 2)
	localparam logic [IDX_W-1:0] PASS_LAST = 7'd64;
	// last byte of the child mask in the count phase
	localparam logic [2:0]       BYTE_LAST = 3'd7;

	typedef struct packed {
		logic [MEMB_W-1:0] membership;
		logic [F_W-1:0]    frobenius;
	} request_t;

	typedef struct packed {
		logic [M_W-1:0]    multiplicity;
		logic [MEMB_W-1:0] gen_low;
		logic [MEMB_W-1:0] gen_high;
		logic [MEMB_W-1:0] child_mask;
		logic [CNT_W-1:0]  child_count;
	} result_t;

	// operation and shared operands broadcast to every cell
	typedef struct packed {
		logic             ld_memb;
		logic             scan;
		logic             ld_ext;
		logic             step;
		logic [F_W-1:0]   f;
		logic [M_W-1:0]   m;
		logic [IDX_W-1:0] a;
	} cell_bus_t;

	function automatic logic [3:0] popcount8(input logic [BYTE_W-1:0] v);
		logic [3:0] c;
		c = '0;
		for (int i = 0; i < BYTE_W; i++) begin
			c = c + 4'(v[i]);
		end
		return c;
	endfunction

endpackage

### hdl/semigroup_generators_and_children_unit.sv
// ----------------------------------------------------------------------------
// semigroup_generators_and_children_unit: numerical semigroup node expander
// Finds multiplicity, minimal generators and child candidates of one node.
//
//  channel   ports                      handshake
//  -------   ------------------------   ----------------------------------
//  request   start, busy, request       taken when start && !busy
//  result    done, result               one-cycle strobe, no back-pressure
//
// A request keeps the unit busy while the multiplicity scan shifts the set one
// index a cycle, the sums pass walks 65 shift amounts through the cell row,
// and the child count adds one byte a cycle.
// done pulses in the cycle in which busy falls; a new request may be taken then.
// arst_n clears the controller; the cell row holds no control state.
// ----------------------------------------------------------------------------
module semigroup_generators_and_children_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  sgc_pkg::request_t    request,
	output logic                 done,
	output sgc_pkg::result_t     result
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_LOAD   = 6'b000010,
		ST_SCAN   = 6'b000100,
		ST_EXTEND = 6'b001000,
		ST_PASS   = 6'b010000,
		ST_COUNT  = 6'b100000
	} state_t;

	state_t                          state_q;
	logic [sgc_pkg::MEMB_W-1:0]      memb_q;
	logic [sgc_pkg::F_W-1:0]         f_q;
	logic [sgc_pkg::IDX_W-1:0]       cnt_q;
	logic [sgc_pkg::M_W-1:0]         m_q;
	logic [sgc_pkg::CNT_W-1:0]       acc_q;
	logic                            done_q;
	sgc_pkg::result_t                result_q;

	sgc_pkg::cell_bus_t              bus;
	logic                            ext_a;
	logic [sgc_pkg::IDX_SPAN-1:0]    gen;
	logic [sgc_pkg::MEMB_W-1:0]      child;
	logic                            scan_stop;
	logic [sgc_pkg::M_W-1:0]         f_plus1;
	logic [sgc_pkg::BYTE_W-1:0]      child_byte;
	logic [sgc_pkg::CNT_W-1:0]       acc_next;

	always_comb begin
		f_plus1    = {1'b0, f_q} + 7'd1;
		scan_stop  = ext_a || (cnt_q == {1'b0, f_q});
		child_byte = child[{cnt_q[2:0], 3'b000} +: sgc_pkg::BYTE_W];
		acc_next   = acc_q + 6'(sgc_pkg::popcount8(child_byte));
		bus.ld_memb = state_q == ST_LOAD;
		bus.scan    = (state_q == ST_SCAN) && !scan_stop;
		bus.ld_ext  = state_q == ST_EXTEND;
		bus.step    = state_q == ST_PASS;
		bus.f       = f_q;
		bus.m       = m_q;
		bus.a       = cnt_q;
	end

	sgc_row u_row (
		.clk   (clk),
		.bus   (bus),
		.memb  (memb_q),
		.ext_a (ext_a),
		.gen   (gen),
		.child (child)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
			acc_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					cnt_q   <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (scan_stop) begin
						state_q <= ST_EXTEND;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				ST_EXTEND: begin
					cnt_q   <= '0;
					state_q <= ST_PASS;
				end
				ST_PASS: begin
					if (cnt_q == sgc_pkg::PASS_LAST) begin
						cnt_q   <= '0;
						acc_q   <= '0;
						state_q <= ST_COUNT;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				ST_COUNT: begin
					acc_q <= acc_next;
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q[2:0] == sgc_pkg::BYTE_LAST) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			memb_q <= request.membership;
			f_q    <= request.frobenius;
		end
		if (state_q == ST_SCAN && scan_stop) begin
			m_q <= ext_a ? cnt_q : f_plus1;
		end
		if (state_q == ST_COUNT && cnt_q[2:0] == sgc_pkg::BYTE_LAST) begin
			result_q.multiplicity <= m_q;
			result_q.gen_low      <= gen[sgc_pkg::MEMB_W-1:0];
			result_q.gen_high     <= gen[sgc_pkg::IDX_SPAN-1:sgc_pkg::MEMB_W];
			result_q.child_mask   <= child;
			result_q.child_count  <= acc_next;
		end
	end

	assign busy   = state_q != ST_IDLE;
	assign done   = done_q;
	assign result = result_q;

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("controller state not one-hot");

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> state_q == ST_LOAD)
		else $error("accepted request did not start loading");

	a_done_after_count: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_COUNT) && !busy)
		else $error("result strobe outside count completion");

	a_mult_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.multiplicity <= ({1'b0, f_q} + 7'd1))
		else $error("multiplicity above f + 1");

	a_child_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.child_count <= 6'd32)
		else $error("child count out of range");

endmodule

### hdl/sgc_cell.sv
// ----------------------------------------------------------------------------
// sgc_cell: one index of the extended set
// Holds the set bit, a left-moving copy for the sum test, a right-moving copy
// that feeds the scan and the broadcast bit, and the removal and child flags.
// ----------------------------------------------------------------------------
module sgc_cell (
	input  logic                    clk,
	input  logic [6:0]              idx,
	input  sgc_pkg::cell_bus_t      bus,
	input  logic                    memb_bit,
	input  logic                    s_in,
	input  logic                    t_in,
	input  logic                    ext_a,
	output logic                    s_out,
	output logic                    t_out,
	output logic                    gen_bit,
	output logic                    child_bit
);

	logic e_q, s_q, t_q, hit_q, nd_q;

	logic [6:0] f7, fm, lo_bound, gap;
	logic [7:0] idx2, a2m1, m2, af;
	logic [8:0] k3, k4, f2, f3;
	logic       in_low, e_new, sum_ok, d_hit, rm_ok, k_ge, k_lt, gap_ok;

	always_comb begin
		f7     = {1'b0, bus.f};
		fm     = f7 + bus.m;
		in_low = idx <= f7;
		e_new  = in_low ? memb_bit : (idx <= fm);
		idx2   = {idx, 1'b0};
		// pair (k-a, a) counts only when 2 <= a <= ceil(k/2)
		a2m1   = {bus.a, 1'b0} - 8'd1;
		sum_ok = (bus.a >= 7'd2) && (a2m1 <= {1'b0, idx});
		af     = {1'b0, bus.a} + {2'b00, bus.f};
		d_hit  = af == idx2;
		m2     = {bus.m, 1'b0};
		rm_ok  = ({1'b0, idx} >= m2) && (idx >= 7'd2);
	end

	always_ff @(posedge clk) begin
		if (bus.ld_memb) begin
			t_q <= memb_bit & in_low;
		end else if (bus.scan) begin
			t_q <= t_in;
		end else if (bus.ld_ext) begin
			e_q   <= e_new;
			s_q   <= e_new;
			t_q   <= e_new;
			hit_q <= 1'b0;
			nd_q  <= 1'b0;
		end else if (bus.step) begin
			hit_q <= hit_q | (s_q & ext_a & sum_ok);
			// ext bit at 2k - f goes by on the broadcast line
			if (d_hit) begin
				nd_q <= ~ext_a;
			end
			s_q <= s_in;
			t_q <= t_in;
		end
	end

	always_comb begin
		lo_bound = (f7 + 7'd1) >> 1;
		k_ge     = idx >= lo_bound;
		k_lt     = idx < f7;
		k3       = {2'b00, idx} + {1'b0, idx, 1'b0};
		k4       = {idx, 2'b00};
		f2       = {2'b00, bus.f, 1'b0};
		f3       = {3'b000, bus.f} + {2'b00, bus.f, 1'b0};
		gap      = f7 - idx;
		gap_ok   = gap < bus.m;
		gen_bit  = e_q & ~(hit_q & rm_ok);
		child_bit = gen_bit & nd_q & k_ge & k_lt & (k3 != f2) & (k4 != f3) & gap_ok;
	end

	assign s_out = s_q;
	assign t_out = t_q;

endmodule

### hdl/sgc_row.sv
// ----------------------------------------------------------------------------
// sgc_row: the row of index cells
// Wires the two neighbor chains and collects the generator and child bits.
// ----------------------------------------------------------------------------
module sgc_row (
	input  logic                             clk,
	input  sgc_pkg::cell_bus_t               bus,
	input  logic [sgc_pkg::MEMB_W-1:0]       memb,
	output logic                             ext_a,
	output logic [sgc_pkg::IDX_SPAN-1:0]     gen,
	output logic [sgc_pkg::MEMB_W-1:0]       child
);

	logic [sgc_pkg::IDX_SPAN-1:0] s_vec, t_vec, s_in_vec, t_in_vec, memb_ext, child_all;

	assign memb_ext = {{(sgc_pkg::IDX_SPAN - sgc_pkg::MEMB_W){1'b0}}, memb};
	// s moves toward higher indices, t toward index zero
	assign s_in_vec = {s_vec[sgc_pkg::IDX_SPAN-2:0], 1'b0};
	assign t_in_vec = {1'b0, t_vec[sgc_pkg::IDX_SPAN-1:1]};
	assign ext_a    = t_vec[0];
	assign child    = child_all[sgc_pkg::MEMB_W-1:0];

	for (genvar i = 0; i < sgc_pkg::IDX_SPAN; i++) begin : g_cell
		sgc_cell u_cell (
			.clk       (clk),
			.idx       (7'(i)),
			.bus       (bus),
			.memb_bit  (memb_ext[i]),
			.s_in      (s_in_vec[i]),
			.t_in      (t_in_vec[i]),
			.ext_a     (ext_a),
			.s_out     (s_vec[i]),
			.t_out     (t_vec[i]),
			.gen_bit   (gen[i]),
			.child_bit (child_all[i])
		);
	end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: node expander of the numerical semigroup tree
// Drives membership/frobenius requests through start/busy, predicts the
// multiplicity, generator bitmap and child mask of each node, and checks
// every done strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

	import sgc_pkg::*;

	localparam int N_RANDOM       = 1850;
	localparam int DRAIN_CYCLES   = 200;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_EVERY     = 400;

	typedef struct {
		request_t req;
		bit       typed;
		result_t  want;
	} node_vec_t;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     start;
	logic     busy;
	request_t request;
	logic     done;
	result_t  result;

	result_t   pending_results[$];
	node_vec_t directed_rows[$];
	int        fails = 0;
	int        idle_cycles;
	bit        burst = 1'b0;

	semigroup_generators_and_children_unit uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	always #4 clk = ~clk;

	// multiplicity, generators and child candidates of one node
	function automatic result_t expand_node(input request_t r);
		logic [IDX_SPAN-1:0] ext;
		logic [IDX_SPAN-1:0] gen;
		int f, m, k, j, d, cnt;
		result_t res;
		f = int'(r.frobenius);
		if (f > MAX_FROB)
			f = MAX_FROB;
		ext = '0;
		for (int i = 0; i <= f; i++)
			ext[i] = r.membership[i];
		m = f + 1;
		for (int i = f; i >= 0; i--)
			if (ext[i])
				m = i;
		for (int i = f + 1; i <= f + m && i < IDX_SPAN; i++)
			ext[i] = 1'b1;
		gen = ext;
		for (k = 2 * m; k <= f + m && k < IDX_SPAN; k++) begin
			if (ext[k] && k >= 2) begin
				for (j = k / 2; j <= k - 2; j++)
					if (ext[j] && ext[k - j])
						gen[k] = 1'b0;
			end
		end
		res = '0;
		res.multiplicity = m[M_W-1:0];
		res.gen_low      = gen[MEMB_W-1:0];
		res.gen_high     = gen[IDX_SPAN-1:MEMB_W];
		cnt = 0;
		for (k = (f + 1) / 2; k < f; k++) begin
			d = 2 * k - f;
			if (gen[k] && !ext[d] && 3 * k != 2 * f && 4 * k != 3 * f && f - k < m) begin
				res.child_mask[k] = 1'b1;
				cnt++;
			end
		end
		res.child_count = cnt[CNT_W-1:0];
		return res;
	endfunction

	task automatic add_row(input logic [MEMB_W-1:0] memb, input int f, input bit typed,
			input int m, input logic [MEMB_W-1:0] lo, input logic [MEMB_W-1:0] hi,
			input logic [MEMB_W-1:0] mask, input int cnt);
		node_vec_t v;
		v.req.membership       = memb;
		v.req.frobenius        = f[F_W-1:0];
		v.typed                = typed;
		v.want.multiplicity    = m[M_W-1:0];
		v.want.gen_low         = lo;
		v.want.gen_high        = hi;
		v.want.child_mask      = mask;
		v.want.child_count     = cnt[CNT_W-1:0];
		directed_rows.push_back(v);
	endtask

	// called at a rising edge; returns at the edge that takes the request
	task automatic issue_request(input request_t r, input bit typed, input result_t want,
			input bit hold_off);
		int gap;
		bit after_idle;
		if ($urandom_range(0, 49) == 0)
			burst = !burst;
		gap = burst ? 0 : $urandom_range(0, 18);
		after_idle = ($urandom_range(0, 2) == 0);
		if (hold_off || gap > 0) begin
			start <= 1'b0;
			if (hold_off) begin
				while (pending_results.size() != 0)
					@(posedge clk);
			end else if (after_idle) begin
				@(posedge clk);
				while (busy)
					@(posedge clk);
			end
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		request <= r;
		do @(posedge clk); while (busy);
		pending_results.push_back(typed ? want : expand_node(r));
	endtask

	task automatic check_field(input string name, input logic [MEMB_W-1:0] want,
			input logic [MEMB_W-1:0] got);
		if (want !== got) begin
			$display("%0t %s expected %h actual %h", $time, name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t unexpected result expected none actual %h", $time, result);
				fails++;
			end else begin
				check_field("multiplicity", MEMB_W'(pending_results[0].multiplicity),
					MEMB_W'(result.multiplicity));
				check_field("gen_low", pending_results[0].gen_low, result.gen_low);
				check_field("gen_high", pending_results[0].gen_high, result.gen_high);
				check_field("child_mask", pending_results[0].child_mask, result.child_mask);
				check_field("child_count", MEMB_W'(pending_results[0].child_count),
					MEMB_W'(result.child_count));
				void'(pending_results.pop_front());
			end
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("FAIL semigroup_generators_and_children_unit");
		$finish;
	end

	initial begin
		request_t         req;
		logic [MEMB_W-1:0] memb;
		logic [MEMB_W-1:0] noise;
		int f, m, p, sel, idx;
		arst_n  = 1'b0;
		start   = 1'b0;
		request = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// empty sets, full sets, frobenius zero, bits above f, single member at 63
		add_row(64'h0, 1, 1, 2, 64'hC, 64'h0, 64'h0, 0);
		add_row(64'h0, 63, 1, 64, 64'h0, '1, 64'h0, 0);
		add_row('1, 63, 1, 0, 64'h7, 64'h0, 64'h0, 0);
		add_row(64'h0, 0, 1, 1, 64'h2, 64'h0, 64'h0, 0);
		add_row('1, 0, 1, 0, 64'h1, 64'h0, 64'h0, 0);
		add_row(64'hFFFF_FFFF_FFFF_FFFE, 0, 1, 1, 64'h2, 64'h0, 64'h0, 0);
		add_row(64'hFFFF_FFFF_FFFF_FFFC, 1, 1, 2, 64'hC, 64'h0, 64'h0, 0);
		add_row(64'h8000_0000_0000_0000, 63, 1, 63, 64'h8000_0000_0000_0000,
			64'h3FFF_FFFF_FFFF_FFFF, 64'h0, 0);
		// ordinary tree nodes, including the 3k == 2f and 4k == 3f exclusions
		add_row(64'h0, 2, 0, 0, 0, 0, 0, 0);
		add_row(64'h8, 4, 0, 0, 0, 0, 0, 0);
		add_row(64'h18, 5, 0, 0, 0, 0, 0, 0);
		add_row(64'h30, 6, 0, 0, 0, 0, 0, 0);
		add_row(64'h68, 7, 0, 0, 0, 0, 0, 0);
		add_row(64'hE0, 8, 0, 0, 0, 0, 0, 0);
		add_row(64'h7AD4A0, 23, 0, 0, 0, 0, 0, 0);
		add_row(64'hFFFF_FFFF_0000_0000, 40, 0, 0, 0, 0, 0, 0);
		add_row(64'hAAAA_AAAA_AAAA_AAAA, 63, 0, 0, 0, 0, 0, 0);
		add_row(64'h5555_5555_5555_5555, 62, 0, 0, 0, 0, 0, 0);
		add_row(64'h1, 10, 0, 0, 0, 0, 0, 0);
		add_row(64'h2, 63, 0, 0, 0, 0, 0, 0);

		foreach (directed_rows[i])
			issue_request(directed_rows[i].req, directed_rows[i].typed,
				directed_rows[i].want, 1'b0);

		for (int n = 0; n < N_RANDOM; n++) begin
			sel   = $urandom_range(0, 99);
			noise = {$urandom, $urandom};
			if (sel < 75) begin
				// closed set above the multiplicity, f removed, random junk above f
				f = $urandom_range(1, 63);
				m = $urandom_range(2, f + 1);
				memb = '0;
				if (m <= f)
					memb[m] = 1'b1;
				p = $urandom_range(0, 100);
				for (int i = m + 1; i < f; i++)
					if ($urandom_range(0, 99) < p)
						memb[i] = 1'b1;
				for (int i = m + 1; i <= f; i++)
					for (int a = m; a <= i - m; a++)
						if (memb[a] && memb[i - a])
							memb[i] = 1'b1;
				memb[f] = 1'b0;
				if (sel >= 55) begin
					repeat ($urandom_range(1, 3)) begin
						idx = $urandom_range(0, f);
						memb[idx] = ~memb[idx];
					end
				end
				if ($urandom_range(0, 1))
					memb = memb | (noise & ~((64'd2 << f) - 64'd1));
			end else if (sel < 90) begin
				memb = noise;
				f = $urandom_range(0, 63);
			end else begin
				f = $urandom_range(0, 63);
				case ($urandom_range(0, 3))
					0: memb = noise | 64'd1;
					1: begin
						memb = noise;
						f = 0;
					end
					2: memb = '0;
					default: memb = '1;
				endcase
			end
			req.membership = memb;
			req.frobenius  = f[F_W-1:0];
			issue_request(req, 1'b0, '0, (n % HOLD_EVERY) == 0);
		end
		start <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("PASS semigroup_generators_and_children_unit");
		else
			$display("FAIL semigroup_generators_and_children_unit");
		$finish;
	end

endmodule
